/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the signed fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 14;

  typedef enum logic [3:0] {
    K_TO_FIXED     = 4'd0,
    K_TO_INT_TRUNC = 4'd1,
    K_TO_INT_ROUND = 4'd2,
    K_ADD          = 4'd3,
    K_SUB          = 4'd4,
    K_ADD_INT      = 4'd5,
    K_SUB_INT      = 4'd6,
    K_MUL          = 4'd7,
    K_MUL_INT      = 4'd8,
    K_DIV          = 4'd9,
    K_DIV_INT      = 4'd10
  } kind_t;

  // Side information that rides alongside the divider
  typedef struct packed {
    logic [DATA_W-1:0] res;     // result of every non-division kind
    logic              is_div;  // take the quotient instead of res
    logic              neg;     // quotient sign
    logic              dz;      // zero divisor
  } fpa_side_t;

endpackage

`default_nettype wire

/* rtl/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Two register stages: simple kinds, the 32x32 product, divider set-up.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned DW        = DATA_W + FRAC_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_vld,
  input  wire logic [3:0]               in_kind,
  input  wire logic signed [DATA_W-1:0] in_a,
  input  wire logic signed [DATA_W-1:0] in_b,
  output logic                          out_vld,
  output fpa_side_t                     out_side,
  output logic [DW-1:0]                 out_dividend,
  output logic [DATA_W-1:0]             out_divisor
);

  localparam logic signed [DATA_W:0]     ONE33  = (DATA_W+1)'(1) << FRAC_BITS;
  localparam logic signed [DATA_W:0]     HALF33 = ONE33 >>> 1;
  localparam logic signed [DATA_W:0]     MASK33 = ONE33 - (DATA_W+1)'(1);
  localparam logic signed [2*DATA_W-1:0] MASK64 =
      ((2*DATA_W)'(1) << FRAC_BITS) - (2*DATA_W)'(1);

  // stage 1
  logic                       vld1;
  kind_t                      kind1;
  logic [DATA_W-1:0]          simple1;
  logic signed [2*DATA_W-1:0] prod1;
  logic [DW-1:0]              dividend1;
  logic [DATA_W-1:0]          divisor1;
  logic                       neg1;
  logic                       dz1;

  logic [DATA_W-1:0]     simple_next;
  logic signed [DATA_W:0] a33;
  logic signed [DATA_W:0] t33;
  logic signed [DATA_W:0] abs_a;
  logic signed [DATA_W:0] abs_b;
  logic [DW-1:0]         dividend_next;
  logic                  b_zero;
  logic                  is_div_kind;

  always_comb begin
    a33         = {in_a[DATA_W-1], in_a};
    t33         = '0;
    simple_next = '0;
    abs_a       = in_a[DATA_W-1] ? -a33 : a33;
    abs_b       = in_b[DATA_W-1] ? -{in_b[DATA_W-1], in_b} : {in_b[DATA_W-1], in_b};
    b_zero      = (in_b == '0);
    is_div_kind = (kind_t'(in_kind) == K_DIV) || (kind_t'(in_kind) == K_DIV_INT);
    if (kind_t'(in_kind) == K_DIV) begin
      dividend_next = {abs_a[DATA_W-1:0], {FRAC_BITS{1'b0}}};
    end else begin
      dividend_next = DW'(abs_a[DATA_W-1:0]);
    end
    case (kind_t'(in_kind))
      K_TO_FIXED:     simple_next = DATA_W'(in_a << FRAC_BITS);
      K_TO_INT_TRUNC: begin
        t33         = a33 + (in_a[DATA_W-1] ? MASK33 : '0);
        simple_next = DATA_W'(t33 >>> FRAC_BITS);
      end
      K_TO_INT_ROUND: begin
        // halves away from zero, then truncate toward zero
        t33         = in_a[DATA_W-1] ? (a33 - HALF33 + MASK33) : (a33 + HALF33);
        simple_next = DATA_W'(t33 >>> FRAC_BITS);
      end
      K_ADD:          simple_next = DATA_W'(in_a + in_b);
      K_SUB:          simple_next = DATA_W'(in_a - in_b);
      K_ADD_INT:      simple_next = DATA_W'(in_a + (in_b << FRAC_BITS));
      K_SUB_INT:      simple_next = DATA_W'(in_a - (in_b << FRAC_BITS));
      default:        simple_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    kind1     <= kind_t'(in_kind);
    simple1   <= simple_next;
    prod1     <= in_a * in_b;
    dividend1 <= dividend_next;
    divisor1  <= b_zero ? DATA_W'(1) : abs_b[DATA_W-1:0];
    neg1      <= in_a[DATA_W-1] ^ in_b[DATA_W-1];
    dz1       <= is_div_kind && b_zero;
  end

  // stage 2: product scaling
  logic signed [2*DATA_W-1:0] prod_adj;
  logic [DATA_W-1:0]          res_next;

  always_comb begin
    prod_adj = prod1 + (prod1[2*DATA_W-1] ? MASK64 : '0);
    case (kind1)
      K_MUL:     res_next = DATA_W'(prod_adj >>> FRAC_BITS);
      K_MUL_INT: res_next = prod1[DATA_W-1:0];
      default:   res_next = simple1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld1;
    end
    out_side.res    <= res_next;
    out_side.is_div <= (kind1 == K_DIV) || (kind1 == K_DIV_INT);
    out_side.neg    <= neg1;
    out_side.dz     <= dz1;
    out_dividend    <= dividend1;
    out_divisor     <= divisor1;
  end

endmodule

`default_nettype wire

/* rtl/fpa_div_stage.sv */
// ----------------------------------------------------------------------------
// fpa_div_stage
// One restoring-division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_stage import fpa_pkg::*; #(
  parameter int unsigned DW = DATA_W + FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [DATA_W-1:0] in_rem,
  input  wire logic [DW-1:0]     in_q,
  input  wire logic [DATA_W-1:0] in_d,
  input  wire fpa_side_t         in_side,
  output logic                   out_vld,
  output logic [DATA_W-1:0]      out_rem,
  output logic [DW-1:0]          out_q,
  output logic [DATA_W-1:0]      out_d,
  output fpa_side_t              out_side
);

  logic [DATA_W:0]   sh;
  logic              qbit;
  logic [DATA_W-1:0] rem_next;

  always_comb begin
    sh   = {in_rem, in_q[DW-1]};
    qbit = (sh >= {1'b0, in_d});
    if (qbit) begin
      rem_next = DATA_W'(sh - {1'b0, in_d});
    end else begin
      rem_next = sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_rem  <= rem_next;
    out_q    <= {in_q[DW-2:0], qbit};
    out_d    <= in_d;
    out_side <= in_side;
  end

endmodule

`default_nettype wire

/* rtl/fpa_divider.sv */
// ----------------------------------------------------------------------------
// fpa_divider
// Fully pipelined unsigned divider, DW stages, side data carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_divider import fpa_pkg::*; #(
  parameter int unsigned DW = DATA_W + FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [DW-1:0]     in_dividend,
  input  wire logic [DATA_W-1:0] in_divisor,
  input  wire fpa_side_t         in_side,
  output logic                   out_vld,
  output logic [DW-1:0]          out_q,
  output fpa_side_t              out_side
);

  logic              vld  [DW+1];
  logic [DATA_W-1:0] rem  [DW+1];
  logic [DW-1:0]     q    [DW+1];
  logic [DATA_W-1:0] d    [DW+1];
  fpa_side_t         side [DW+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = '0;
  assign q[0]    = in_dividend;
  assign d[0]    = in_divisor;
  assign side[0] = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    fpa_div_stage #(.DW(DW)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (vld[i]),
      .in_rem   (rem[i]),
      .in_q     (q[i]),
      .in_d     (d[i]),
      .in_side  (side[i]),
      .out_vld  (vld[i+1]),
      .out_rem  (rem[i+1]),
      .out_q    (q[i+1]),
      .out_d    (d[i+1]),
      .out_side (side[i+1])
    );
  end

  assign out_vld  = vld[DW];
  assign out_q    = q[DW];
  assign out_side = side[DW];

endmodule

`default_nettype wire

/* rtl/fixed_point_q17_14_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_q17_14_alu
// Signed fixed-point arithmetic unit, FRAC_BITS fraction bits (17.14).
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with kind, operand_a and operand_b; the beat is taken at
//   any edge where start is high and busy is low. busy is never raised, so
//   a new beat may be offered every cycle.
//   Every beat gives exactly one result beat: done is high for one cycle
//   with result and divide_by_zero. Results leave in the order the beats
//   came in. The receiver cannot stall, so none is needed.
//   From the accepting edge to the edge that takes the result a beat passes
//   one input register, two front stages (simple kinds, 32x32 multiply,
//   product scaling), one restoring divider step per quotient bit
//   (32 + FRAC_BITS stages) and an output register. Every kind takes the
//   same path, so the divider depth sets the latency; throughput is one
//   beat per cycle.
//   Divide by zero gives result 0 with divide_by_zero set.
//   Reset (rst, synchronous) clears every valid bit; beats in flight are
//   dropped and done stays low until new beats arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_q17_14_alu import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [3:0]               kind,
  input  wire logic signed [DATA_W-1:0] operand_a,
  input  wire logic signed [DATA_W-1:0] operand_b,
  output logic                          done,
  output logic signed [DATA_W-1:0]      result,
  output logic                          divide_by_zero
);

  // quotient width: |a| << FRAC_BITS needs 32 + FRAC_BITS bits
  localparam int unsigned DW = DATA_W + FRAC_BITS;

  assign busy = 1'b0;

  // input register
  logic                     vld0;
  logic [3:0]               kind0;
  logic signed [DATA_W-1:0] a0;
  logic signed [DATA_W-1:0] b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= start && !busy;
    end
    kind0 <= kind;
    a0    <= operand_a;
    b0    <= operand_b;
  end

  // front stages
  logic              vld2;
  fpa_side_t         side2;
  logic [DW-1:0]     dividend2;
  logic [DATA_W-1:0] divisor2;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (vld0),
    .in_kind      (kind0),
    .in_a         (a0),
    .in_b         (b0),
    .out_vld      (vld2),
    .out_side     (side2),
    .out_dividend (dividend2),
    .out_divisor  (divisor2)
  );

  // divider; non-division results ride along in the side data
  logic          vld_d;
  logic [DW-1:0] q_d;
  fpa_side_t     side_d;

  fpa_divider #(.DW(DW)) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_vld      (vld2),
    .in_dividend (dividend2),
    .in_divisor  (divisor2),
    .in_side     (side2),
    .out_vld     (vld_d),
    .out_q       (q_d),
    .out_side    (side_d)
  );

  // sign fix-up and final selection
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] result_next;

  always_comb begin
    quot = side_d.neg ? DATA_W'(-q_d[DATA_W-1:0]) : q_d[DATA_W-1:0];
    if (side_d.dz) begin
      result_next = '0;
    end else if (side_d.is_div) begin
      result_next = quot;
    end else begin
      result_next = side_d.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_d;
    end
    result         <= result_next;
    divide_by_zero <= side_d.dz;
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  localparam int unsigned LAT = DW + 4;

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result beat missing at expected latency");

  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (result == '0))
    else $error("divide by zero with non-zero result");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(vld_d))
    else $error("done raised without a beat leaving the divider");

endmodule

`default_nettype wire
